[src/eld_pkg.sv]
package eld_pkg;

  // Angle and CORDIC sizing.
  localparam int ACC_BITS     = 24;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_IW      = 5;   // index width of the 24-entry arctangent table
  localparam int CW           = 34;  // CORDIC x/y and sin/cos width, Q2.30 plus headroom
  localparam int ZW           = 32;  // residual angle width, 2^32 per turn
  localparam int MBW          = 18;  // multiplier B operand width
  localparam int PW           = CW + MBW;  // multiplier product width
  localparam int AW           = 2 * CW;    // product accumulator width

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [14:0] QUARTER_TURN = 15'd16384;

  // Configuration register indexes.
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_SENSITIVITY = 2'd0;
  localparam logic [CFG_IW-1:0] REG_PITCH_LIMIT = 2'd1;

  localparam logic [15:0] SENSITIVITY_RESET = 16'd2330;
  localparam logic [14:0] PITCH_LIMIT_RESET = 15'd16202;

  typedef struct packed {
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
  } item_t;

  typedef struct packed {
    logic signed [15:0] look_x;
    logic signed [15:0] look_y;
    logic signed [15:0] look_z;
    logic        [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
  } result_t;

  // atan(2^-i) in 2^32-per-turn units.
  function automatic logic [29:0] atan_angle(input logic [ATAN_IW-1:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10680862;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[src/euler_angle_look_direction.sv]
// Takes no new item until the last one's result has been issued: item_stall is high
// from the transfer until the result is loaded, and a stalled receiver prolongs it.
// One CORDIC stage runs CORDIC_STEPS steps for pitch then for yaw, and one
// 34x18 multiplier forms the delta products whole and both look products in two halves each.
// Reset (rst, synchronous): yaw and pitch cleared, registers to their defaults
// (sensitivity 2330, pitch limit 16202), no result pending.
module euler_angle_look_direction (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  eld_pkg::item_t           item,
  output logic                     result_valid,
  input  logic                     result_stall,
  output eld_pkg::result_t         result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [eld_pkg::CFG_IW-1:0] cfg_index,
  input  logic [15:0]              cfg_data
);
  import eld_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MULX   = 4'd1;
  localparam logic [3:0] S_MULY   = 4'd2;
  localparam logic [3:0] S_PCLAMP = 4'd3;
  localparam logic [3:0] S_LOAD   = 4'd4;
  localparam logic [3:0] S_CORD   = 4'd5;
  localparam logic [3:0] S_ROT    = 4'd6;
  localparam logic [3:0] S_MX0    = 4'd7;
  localparam logic [3:0] S_MX1    = 4'd8;
  localparam logic [3:0] S_MZ0    = 4'd9;
  localparam logic [3:0] S_MZ1    = 4'd10;
  localparam logic [3:0] S_MZE    = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  localparam logic [ATAN_IW-1:0] LAST_STEP = ATAN_IW'(CORDIC_STEPS - 1);

  logic [3:0]               state;
  logic [15:0]              sensitivity;
  logic [14:0]              pitch_limit;
  logic [ACC_BITS-1:0]      yaw_accum;
  logic signed [ACC_BITS-1:0] pitch_accum;
  logic signed [15:0]       dx;
  logic signed [15:0]       dy;
  logic                     pass;   // low: pitch pass, high: yaw pass
  logic [ATAN_IW-1:0]       step;
  logic [1:0]               quad;
  logic signed [CW-1:0]     x;
  logic signed [CW-1:0]     y;
  logic signed [ZW-1:0]     z;
  logic signed [CW-1:0]     cp;
  logic signed [CW-1:0]     sp;
  logic signed [CW-1:0]     cy;
  logic signed [CW-1:0]     sy;
  logic signed [PW-1:0]     prod;
  logic signed [AW-1:0]     acc_x;
  logic signed [AW-1:0]     acc_z;

  logic signed [CW-1:0]     mul_a;
  logic signed [MBW-1:0]    mul_b;
  logic signed [PW-1:0]     mul_p;
  logic signed [CW-1:0]     x_sh;
  logic signed [CW-1:0]     y_sh;
  logic signed [ZW-1:0]     atan_z;
  logic [ACC_BITS-1:0]      angle_src;
  logic [31:0]              angle32;
  logic [14:0]              lim;
  logic signed [CW-1:0]     lim_acc;
  logic signed [CW-1:0]     p_sum;
  logic signed [CW-1:0]     p_clamped;
  logic signed [CW-1:0]     rot_c;
  logic signed [CW-1:0]     rot_s;
  logic signed [AW-1:0]     round_x;
  logic signed [AW-1:0]     round_z;
  logic signed [CW-1:0]     round_y;
  result_t                  result_next;

  function automatic logic signed [15:0] sat_q15(input logic signed [22:0] v);
    logic signed [15:0] r;
    if (v > 23'sd32767) begin
      r = 16'sd32767;
    end else if (v < -23'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;

  // Shared multiplier operand selection. Look products split cos(pitch) into
  // an unsigned low half and a signed high half.
  always_comb begin
    mul_a = CW'(dx);
    mul_b = $signed({2'b00, sensitivity});
    unique case (state)
      S_MULY: mul_a = CW'(dy);
      S_MX0: begin
        mul_a = sy;
        mul_b = $signed({2'b00, cp[15:0]});
      end
      S_MX1: begin
        mul_a = sy;
        mul_b = cp[CW-1:16];
      end
      S_MZ0: begin
        mul_a = cy;
        mul_b = $signed({2'b00, cp[15:0]});
      end
      S_MZ1: begin
        mul_a = cy;
        mul_b = cp[CW-1:16];
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Pitch update and clamp.
  assign lim       = (pitch_limit > QUARTER_TURN) ? QUARTER_TURN : pitch_limit;
  assign lim_acc   = $signed({11'b0, lim, 8'b0});
  assign p_sum     = CW'(pitch_accum) + prod[CW-1:0];
  assign p_clamped = (p_sum > lim_acc) ? lim_acc : ((p_sum < -lim_acc) ? -lim_acc : p_sum);

  // Angle for the CORDIC pass: top ANGLE_BITS of the accumulator at the top
  // of a 32-bit binary angle.
  assign angle_src = pass ? yaw_accum : pitch_accum;
  assign angle32   = 32'(angle_src[ACC_BITS-1 -: ANGLE_BITS]) << (32 - ANGLE_BITS);

  assign x_sh   = x >>> step;
  assign y_sh   = y >>> step;
  assign atan_z = $signed(ZW'(atan_angle(step)));

  always_comb begin
    unique case (quad)
      2'd0: begin
        rot_c = x;
        rot_s = y;
      end
      2'd1: begin
        rot_c = -y;
        rot_s = x;
      end
      2'd2: begin
        rot_c = -x;
        rot_s = -y;
      end
      default: begin
        rot_c = y;
        rot_s = -x;
      end
    endcase
  end

  assign round_x = acc_x + (AW'(1) <<< 44);
  assign round_z = acc_z + (AW'(1) <<< 44);
  assign round_y = sp + CW'(16384);

  always_comb begin
    result_next.look_x      = sat_q15(23'(round_x >>> 45));
    result_next.look_y      = sat_q15(23'(round_y >>> 15));
    result_next.look_z      = sat_q15(23'(round_z >>> 45));
    result_next.yaw_angle   = yaw_accum[ACC_BITS-1:8];
    result_next.pitch_angle = pitch_accum[ACC_BITS-1:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sensitivity  <= SENSITIVITY_RESET;
      pitch_limit  <= PITCH_LIMIT_RESET;
      yaw_accum    <= '0;
      pitch_accum  <= '0;
      result_valid <= 1'b0;
      pass         <= 1'b0;
      step         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SENSITIVITY) begin
          sensitivity <= cfg_data;
        end else if (cfg_index == REG_PITCH_LIMIT) begin
          pitch_limit <= cfg_data[14:0];
        end
      end

      // In S_FIN a new result replaces the one being transferred.
      if (result_valid && !result_stall && state != S_FIN) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            dx    <= item.delta_x;
            dy    <= item.delta_y;
            state <= S_MULX;
          end
        end
        S_MULX: begin
          prod  <= mul_p;
          state <= S_MULY;
        end
        S_MULY: begin
          yaw_accum <= yaw_accum + prod[ACC_BITS-1:0];
          prod      <= mul_p;
          state     <= S_PCLAMP;
        end
        S_PCLAMP: begin
          pitch_accum <= p_clamped[ACC_BITS-1:0];
          pass        <= 1'b0;
          state       <= S_LOAD;
        end
        S_LOAD: begin
          x     <= CORDIC_GAIN;
          y     <= '0;
          z     <= $signed({2'b00, angle32[29:0]});
          quad  <= angle32[31:30];
          step  <= '0;
          state <= S_CORD;
        end
        S_CORD: begin
          if (!z[ZW-1]) begin
            x <= x - y_sh;
            y <= y + x_sh;
            z <= z - atan_z;
          end else begin
            x <= x + y_sh;
            y <= y - x_sh;
            z <= z + atan_z;
          end
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (!pass) begin
            cp    <= rot_c;
            sp    <= rot_s;
            pass  <= 1'b1;
            state <= S_LOAD;
          end else begin
            cy    <= rot_c;
            sy    <= rot_s;
            state <= S_MX0;
          end
        end
        S_MX0: begin
          prod  <= mul_p;
          state <= S_MX1;
        end
        S_MX1: begin
          acc_x <= AW'(prod);
          prod  <= mul_p;
          state <= S_MZ0;
        end
        S_MZ0: begin
          acc_x <= acc_x + (AW'(prod) <<< 16);
          prod  <= mul_p;
          state <= S_MZ1;
        end
        S_MZ1: begin
          acc_z <= -AW'(prod);
          prod  <= mul_p;
          state <= S_MZE;
        end
        S_MZE: begin
          acc_z <= acc_z - (AW'(prod) <<< 16);
          state <= S_FIN;
        end
        S_FIN: begin
          // Hold here until the previous result has been transferred.
          if (!result_valid || !result_stall) begin
            result       <= result_next;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[verif/euler_angle_look_direction_tb.sv]
`timescale 1ns / 100ps

module euler_angle_look_direction_tb;
  import eld_pkg::*;

  localparam int ANGLE_USED = (ANGLE_BITS < 12) ? 12 : ((ANGLE_BITS > 24) ? 24 : ANGLE_BITS);
  localparam int STEPS_USED = (CORDIC_STEPS < 1) ? 1 : ((CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SEGMENTS = 13;
  localparam int SEGMENT_ITEMS = 100;
  // Index with no register behind it.
  localparam logic [CFG_IW-1:0] REG_NONE = 2'd3;

  localparam longint ATAN_TABLE [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  class look_scoreboard;
    logic [15:0] sensitivity;
    logic [14:0] pitch_limit;
    logic [23:0] yaw_acc;
    longint      pitch_acc;
    result_t     look_expected[$];
    int          mismatch_count;

    function new();
      sensitivity = SENSITIVITY_RESET;
      pitch_limit = PITCH_LIMIT_RESET;
      yaw_acc = '0;
      pitch_acc = 0;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] index, logic [15:0] data);
      if (index == REG_SENSITIVITY) begin
        sensitivity = data;
      end else if (index == REG_PITCH_LIMIT) begin
        pitch_limit = data[14:0];
      end
    endfunction

    function logic signed [15:0] sat16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
    endfunction

    // Returns cosine and sine in Q2.30 for a 24-bit turn fraction.
    function void rotate(input logic [23:0] angle, output longint c, output longint s);
      logic [31:0] a;
      longint x, y, z, dx, dy;
      a = {angle[23 -: ANGLE_USED], {(32 - ANGLE_USED){1'b0}}};
      z = longint'({2'b00, a[29:0]});
      x = longint'(CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < STEPS_USED; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_TABLE[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_TABLE[i];
        end
      end
      case (a[31:30])
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function result_t predict_look(item_t it);
      longint dx, dy, lim, p, cy, sy, cp, sp;
      result_t r;
      dx = longint'($signed(it.delta_x));
      dy = longint'($signed(it.delta_y));
      yaw_acc = 24'(longint'(yaw_acc) + dx * longint'(sensitivity));
      lim = (pitch_limit > QUARTER_TURN) ? longint'(QUARTER_TURN) : longint'(pitch_limit);
      lim = lim * 256;
      p = pitch_acc + dy * longint'(sensitivity);
      if (p > lim) p = lim;
      if (p < -lim) p = -lim;
      pitch_acc = p;
      rotate(yaw_acc, cy, sy);
      rotate(p[23:0], cp, sp);
      r.look_x = sat16((sy * cp + (longint'(1) <<< 44)) >>> 45);
      r.look_y = sat16((sp + 16384) >>> 15);
      r.look_z = sat16((-(cy * cp) + (longint'(1) <<< 44)) >>> 45);
      r.yaw_angle = yaw_acc[23:8];
      r.pitch_angle = 16'(p >>> 8);
      return r;
    endfunction

    function void note_item(item_t it);
      look_expected.push_back(predict_look(it));
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (look_expected.size() == 0) begin
        $error("result transfer with no item outstanding");
        mismatch_count++;
        return;
      end
      want = look_expected.pop_front();
      compare("look_x", want.look_x, got.look_x);
      compare("look_y", want.look_y, got.look_y);
      compare("look_z", want.look_z, got.look_z);
      compare("yaw_angle", want.yaw_angle, got.yaw_angle);
      compare("pitch_angle", want.pitch_angle, got.pitch_angle);
    endfunction

    function int pending();
      return look_expected.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  item_t              item = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  result_t            result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_IW-1:0]  cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  look_scoreboard sb = new();
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int cycle_count = 0;

  euler_angle_look_direction dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("euler_angle_look_direction: mismatch");
      $finish;
    end
  end

  // Receiver stalls come in bursts; stall_pct sets how often a burst starts.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      stall_left = $urandom_range(0, 17);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // All driving tasks are entered and left at a falling edge.
  task automatic send_item(input logic [15:0] dx, input logic [15:0] dy);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    item_valid = 1'b1;
    item = {dx, dy};
    do @(posedge clk); while (item_stall);
    sb.note_item(item);
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] index, input logic [15:0] data);
    drain();
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] rand_delta();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'($urandom_range(0, 128) - 64);
      5, 6: return 16'($urandom_range(0, 4095) - 2048);
      7, 8: return 16'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'hFFFF;
          3: return 16'h0001;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] rand_sensitivity();
    case ($urandom_range(0, 5))
      0: return SENSITIVITY_RESET;
      1: return 16'd0;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(1, 512));
      4: return 16'($urandom_range(2048, 8192));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] rand_pitch_limit();
    case ($urandom_range(0, 5))
      0: return 16'(QUARTER_TURN);
      1: return 16'd0;
      2: return 16'(PITCH_LIMIT_RESET);
      3: return 16'($urandom_range(16385, 32767));
      4: return 16'($urandom_range(1, 256));
      default: return 16'($urandom_range(0, 16384));
    endcase
  endfunction

  function automatic int rand_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    gap_pct = 20;
    stall_pct = 20;
    send_item(16'sd0, 16'sd0);
    send_item(16'sd1, -16'sd1);
    send_item(-16'sd1, 16'sd1);
    send_item(16'sd32767, 16'sd32767);
    send_item(-16'sd32768, -16'sd32768);
    send_item(16'sd0, 16'sd0);

    // With 128 angle units per pixel, 128 pixels is exactly a quarter turn.
    write_reg(REG_SENSITIVITY, 16'd32768);
    write_reg(REG_PITCH_LIMIT, 16'(QUARTER_TURN));
    repeat (4) send_item(16'sd128, 16'sd128);
    send_item(16'sd0, -16'sd256);

    // A limit above a quarter turn acts as a quarter turn.
    write_reg(REG_PITCH_LIMIT, 16'd32767);
    send_item(16'sd32767, 16'sd32767);
    send_item(-16'sd32768, -16'sd32768);

    // Lowering the limit pulls the stored pitch in on the next item.
    write_reg(REG_PITCH_LIMIT, 16'd1000);
    send_item(16'sd0, 16'sd0);

    write_reg(REG_PITCH_LIMIT, 16'd0);
    send_item(16'sd5, 16'sd300);
    send_item(-16'sd5, -16'sd300);

    write_reg(REG_SENSITIVITY, 16'd0);
    send_item(16'sd32767, -16'sd32768);

    write_reg(REG_NONE, 16'hFFFF);
    send_item(16'sd0, 16'sd0);

    write_reg(REG_SENSITIVITY, 16'hFFFF);
    write_reg(REG_PITCH_LIMIT, 16'(PITCH_LIMIT_RESET));
    send_item(16'sd32767, 16'sd32767);
    send_item(-16'sd32768, -16'sd32768);
    send_item(16'sd12345, -16'sd4321);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      write_reg(REG_SENSITIVITY, rand_sensitivity());
      write_reg(REG_PITCH_LIMIT, rand_pitch_limit());
      // The closing segment runs with no idling on either side.
      gap_pct = (seg == SEGMENTS - 1) ? 0 : rand_idle_pct();
      stall_pct = (seg == SEGMENTS - 1) ? 0 : rand_idle_pct();
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        send_item(rand_delta(), rand_delta());
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("euler_angle_look_direction: match");
    end else begin
      $display("euler_angle_look_direction: mismatch");
    end
    $finish;
  end

endmodule

[euler_angle_look_direction.f]
src/eld_pkg.sv
src/euler_angle_look_direction.sv
verif/euler_angle_look_direction_tb.sv
